### design/slsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slsd_pkg
// Shared types and constants for the sync/length/sum deframer.
// ----------------------------------------------------------------------------
package slsd_pkg;

  // Register map of the configuration port
  localparam int unsigned CfgIndexWidth = 2;
  localparam logic [CfgIndexWidth-1:0] CFG_SYNC_WORD = 2'd0;
  localparam logic [CfgIndexWidth-1:0] CFG_CAPACITY  = 2'd1;

  localparam int unsigned WordWidth  = 32;
  localparam int unsigned CapWidth   = 17;
  localparam int unsigned IndexWidth = 16;

  localparam logic [WordWidth-1:0] SYNC_RESET = 32'h0102_0304;
  localparam logic [CapWidth-1:0]  CAP_RESET  = 17'd256;

  // Reach of the word index
  localparam int unsigned IndexReach = 65536;
  localparam int unsigned MaxWordsDefault = 65536;

  // Frame phase, also the reported phase code
  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_SIZE     = 3'd1,
    PH_PAYLOAD  = 3'd2,
    PH_CHECKSUM = 3'd3,
    PH_COMPLETE = 3'd4
  } phase_t;

  // One result item
  typedef struct packed {
    phase_t                phase_code;
    logic                  word_valid;
    logic [IndexWidth-1:0] word_index;
    logic [WordWidth-1:0]  word_data;
    logic [WordWidth-1:0]  frame_words;
  } result_t;

endpackage

### design/slsd_frame_fsm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slsd_frame_fsm
// Frame phase tracker: holds configuration, phase, count, sum and length,
// and forms the result for the word presented this cycle.
// ----------------------------------------------------------------------------
module slsd_frame_fsm #(
  parameter int unsigned MAX_WORDS = slsd_pkg::MaxWordsDefault
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 accept,
  input  logic [slsd_pkg::WordWidth-1:0]       in_word,
  input  logic                                 cfg_we,
  input  logic [slsd_pkg::CfgIndexWidth-1:0]   cfg_index,
  input  logic [slsd_pkg::WordWidth-1:0]       cfg_data,
  output slsd_pkg::result_t                    result
);
  import slsd_pkg::*;

  // Hard limit on stored words: least of MAX_WORDS and the index reach
  localparam int unsigned CapLimitInt = (MAX_WORDS < IndexReach) ? MAX_WORDS : IndexReach;
  localparam logic [CapWidth-1:0] CapLimit = CapWidth'(CapLimitInt);

  logic [WordWidth-1:0] sync_word;
  logic [CapWidth-1:0]  capacity_words;
  phase_t               phase, phase_next;
  logic [WordWidth-1:0] word_count, word_count_next;
  logic [WordWidth-1:0] running_sum, running_sum_next;
  logic [WordWidth-1:0] expected_words, expected_words_next;

  logic [CapWidth-1:0]  eff_cap;
  logic [WordWidth-1:0] count_inc;
  logic                 sync_hit;
  logic                 in_capacity;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_word      <= SYNC_RESET;
      capacity_words <= CAP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SYNC_WORD: sync_word      <= cfg_data;
        CFG_CAPACITY:  capacity_words <= cfg_data[CapWidth-1:0];
        default:       ;
      endcase
    end
  end

  // Shared terms
  assign eff_cap     = (capacity_words > CapLimit) ? CapLimit : capacity_words;
  assign count_inc   = word_count + 32'd1;
  assign sync_hit    = (in_word == sync_word);
  assign in_capacity = (word_count < {{(WordWidth-CapWidth){1'b0}}, eff_cap});

  // Next state
  always_comb begin
    phase_next          = phase;
    word_count_next     = word_count;
    running_sum_next    = running_sum;
    expected_words_next = expected_words;
    case (phase)
      PH_SIZE: begin
        expected_words_next = in_word;
        phase_next          = PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        running_sum_next = running_sum + in_word;
        word_count_next  = count_inc;
        phase_next       = (count_inc >= expected_words) ? PH_CHECKSUM : PH_PAYLOAD;
      end
      PH_CHECKSUM: begin
        phase_next = (in_word == running_sum) ? PH_COMPLETE : PH_IDLE;
      end
      default: begin
        // idle and complete both hunt for sync
        if (sync_hit) begin
          word_count_next  = '0;
          running_sum_next = '0;
          phase_next       = PH_SIZE;
        end else begin
          phase_next = PH_IDLE;
        end
      end
    endcase
  end

  // Result for the current word
  always_comb begin
    result             = '0;
    result.phase_code  = phase_next;
    if (phase == PH_PAYLOAD && in_capacity) begin
      result.word_valid = 1'b1;
      result.word_index = word_count[IndexWidth-1:0];
      result.word_data  = in_word;
    end
    if (phase == PH_CHECKSUM && in_word == running_sum) begin
      result.frame_words = word_count;
    end
  end

  // State registers advance on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      word_count     <= '0;
      running_sum    <= '0;
      expected_words <= '0;
    end else if (accept) begin
      phase          <= phase_next;
      word_count     <= word_count_next;
      running_sum    <= running_sum_next;
      expected_words <= expected_words_next;
    end
  end

`ifndef SYNTHESIS
  a_sync_starts_frame: assert property (@(posedge clk) disable iff (rst)
    accept && (phase == PH_IDLE || phase == PH_COMPLETE) && sync_hit
    |=> phase == PH_SIZE && word_count == '0 && running_sum == '0)
    else $error("sync word did not open a frame");

  a_hold_without_accept: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(phase) && $stable(word_count) && $stable(running_sum))
    else $error("frame state moved without an accepted word");

  a_payload_counts: assert property (@(posedge clk) disable iff (rst)
    accept && phase == PH_PAYLOAD |=> word_count == $past(word_count) + 32'd1)
    else $error("payload word not counted");
`endif

endmodule

### design/sync_length_sum_deframer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_length_sum_deframer_core
// Extracts sync/length/payload/checksum frames from a 32-bit word stream.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake            Payload
// in       in   in_valid/in_ready    in_word
// out      out  out_valid/out_ready  phase_code, word_valid, word_index,
//                                    word_data, frame_words
// cfg      in   cfg_we               cfg_index, cfg_data
//
// One word per cycle unless out stalls; a result shows the cycle after accept.
// The only state loop is the phase/count/sum update, one add and compare deep.
// A single output register decouples the sides: a word is taken while the
// held result is being taken in the same cycle, or when the register is empty.
// Reset (synchronous) restores sync 0x01020304, capacity 256, phase idle.
// ----------------------------------------------------------------------------
module sync_length_sum_deframer_core #(
  parameter int unsigned MAX_WORDS = slsd_pkg::MaxWordsDefault
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [slsd_pkg::WordWidth-1:0]       in_word,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [2:0]                           phase_code,
  output logic                                 word_valid,
  output logic [slsd_pkg::IndexWidth-1:0]      word_index,
  output logic [slsd_pkg::WordWidth-1:0]       word_data,
  output logic [slsd_pkg::WordWidth-1:0]       frame_words,
  input  logic                                 cfg_we,
  input  logic [slsd_pkg::CfgIndexWidth-1:0]   cfg_index,
  input  logic [slsd_pkg::WordWidth-1:0]       cfg_data
);
  import slsd_pkg::*;

  logic    accept;
  result_t result_next;
  result_t result;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  slsd_frame_fsm #(
    .MAX_WORDS (MAX_WORDS)
  ) u_fsm (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_word   (in_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .result    (result_next)
  );

  // Output request register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

  assign phase_code  = result.phase_code;
  assign word_valid  = result.word_valid;
  assign word_index  = result.word_index;
  assign word_data   = result.word_data;
  assign frame_words = result.frame_words;

`ifndef SYNTHESIS
  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted word produced no result");

  a_frame_only_complete: assert property (@(posedge clk) disable iff (rst)
    out_valid && phase_code != PH_COMPLETE |-> frame_words == '0)
    else $error("frame count outside complete phase");

  a_word_in_payload: assert property (@(posedge clk) disable iff (rst)
    out_valid && word_valid |-> phase_code == PH_PAYLOAD || phase_code == PH_CHECKSUM)
    else $error("stored word outside payload");
`endif

endmodule

### test/tb_sync_length_sum_deframer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sync_length_sum_deframer_core
// Self-checking bench for the sync/length/sum deframer. Word requests are
// queued per configuration phase and driven with random gaps, but for one
// steady phase. Each accepted word runs through a local frame tracker, and
// every result request is compared field by field with the oldest
// prediction. The phases cover the register extremes, well-formed, corrupted
// and truncated frames, and stray words.
// ----------------------------------------------------------------------------
module tb_sync_length_sum_deframer_core;
  import slsd_pkg::*;

  localparam int unsigned MaxWords   = MaxWordsDefault;
  localparam int unsigned WatchLimit = 5000;
  localparam int unsigned PrintLimit = 200;
  localparam int unsigned PhaseWords = 140;

  // Register indexes past the end of the map; writes there must be ignored
  localparam logic [CfgIndexWidth-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CfgIndexWidth-1:0] CFG_SPARE_B = 2'd3;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [WordWidth-1:0]     in_word = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [2:0]               phase_code;
  logic                     word_valid;
  logic [IndexWidth-1:0]    word_index;
  logic [WordWidth-1:0]     word_data;
  logic [WordWidth-1:0]     frame_words;
  logic                     cfg_we = 1'b0;
  logic [CfgIndexWidth-1:0] cfg_index = CFG_SYNC_WORD;
  logic [WordWidth-1:0]     cfg_data = '0;

  // Bench copy of the registers and of the frame state
  logic [WordWidth-1:0] sync_cfg = SYNC_RESET;
  logic [CapWidth-1:0]  cap_cfg = CAP_RESET;
  phase_t               frame_phase = PH_IDLE;
  logic [WordWidth-1:0] word_cnt = '0;
  logic [WordWidth-1:0] word_sum = '0;
  logic [WordWidth-1:0] frame_len = '0;

  logic [WordWidth-1:0] pending_words[$];
  result_t              expected_results[$];
  bit                   in_taken = 1'b0;
  bit                   steady_flow = 1'b0;
  int unsigned          mismatches = 0;
  int unsigned          idle_cycles = 0;

  sync_length_sum_deframer_core #(
    .MAX_WORDS(MaxWords)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_word(in_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .phase_code(phase_code),
    .word_valid(word_valid),
    .word_index(word_index),
    .word_data(word_data),
    .frame_words(frame_words),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // Advance the frame tracker by one word and return the result it gives
  function automatic result_t deframe_step(input logic [WordWidth-1:0] w);
    result_t              r;
    logic [WordWidth-1:0] cap_eff;
    r = '0;
    cap_eff = WordWidth'(cap_cfg);
    if (cap_eff > MaxWords) cap_eff = MaxWords;
    if (cap_eff > IndexReach) cap_eff = IndexReach;
    case (frame_phase)
      PH_SIZE: begin
        frame_len = w;
        frame_phase = PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        // words past the buffer still go into the sum
        if (word_cnt < cap_eff) begin
          r.word_valid = 1'b1;
          r.word_index = word_cnt[IndexWidth-1:0];
          r.word_data = w;
        end
        word_sum = word_sum + w;
        word_cnt = word_cnt + 1;
        if (word_cnt >= frame_len) frame_phase = PH_CHECKSUM;
      end
      PH_CHECKSUM: begin
        if (w == word_sum) begin
          frame_phase = PH_COMPLETE;
          r.frame_words = word_cnt;
        end else begin
          frame_phase = PH_IDLE;
        end
      end
      default: begin
        // idle and complete both hunt for the sync word
        if (w == sync_cfg) begin
          word_cnt = '0;
          word_sum = '0;
          frame_phase = PH_SIZE;
        end else begin
          frame_phase = PH_IDLE;
        end
      end
    endcase
    r.phase_code = frame_phase;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [WordWidth-1:0] want,
                             input logic [WordWidth-1:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= PrintLimit)
        $display("%0t: %s mismatch: expected 0x%08h, got 0x%08h", $time, name, want, got);
    end
  endtask

  task automatic write_reg(input logic [CfgIndexWidth-1:0] idx,
                           input logic [WordWidth-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == CFG_SYNC_WORD) sync_cfg = val;
    else if (idx == CFG_CAPACITY) cap_cfg = val[CapWidth-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Sync, length, sent payload words, then the checksum (corrupted unless good)
  task automatic push_frame(input int unsigned len, input int unsigned sent, input bit good);
    logic [WordWidth-1:0] sum;
    logic [WordWidth-1:0] w;
    sum = '0;
    pending_words.push_back(sync_cfg);
    pending_words.push_back(len);
    for (int unsigned i = 0; i < sent; i++) begin
      w = $urandom;
      sum = sum + w;
      pending_words.push_back(w);
    end
    pending_words.push_back(good ? sum : sum ^ (32'h1 << $urandom_range(0, 31)));
  endtask

  // Mostly clean frames; the rest bad sums, stray words and cut-short frames
  task automatic push_random_traffic();
    int unsigned pick;
    int unsigned len;
    int unsigned nw;
    pick = $urandom_range(0, 99);
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 10);
    // a length equal to the sync word would restart a frame after a desync
    if (len == sync_cfg) len++;
    nw = (len == 0) ? 1 : len;
    if (pick < 70) push_frame(len, nw, 1'b1);
    else if (pick < 80) push_frame(len, nw, 1'b0);
    else if (pick < 90) repeat ($urandom_range(1, 3)) pending_words.push_back($urandom);
    else push_frame(len, $urandom_range(0, nw - 1), 1'b0);
  endtask

  task automatic wait_drained();
    while (pending_words.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Word request driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_words.size() != 0 && (steady_flow || $urandom_range(0, 99) >= 9)) begin
        in_word <= pending_words.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure
  always @(negedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= steady_flow || ($urandom_range(0, 99) >= 9);
  end

  // Monitor: check results, predict accepted words, watch for a hang
  always @(posedge clk) begin : monitor
    result_t want;
    if (rst) begin
      in_taken = 1'b0;
      idle_cycles = 0;
    end else begin
      in_taken = in_valid && in_ready;
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= PrintLimit)
            $display("%0t: result with nothing expected: expected none, got phase %0d",
                     $time, phase_code);
        end else begin
          want = expected_results.pop_front();
          check_field("phase_code", WordWidth'(want.phase_code), WordWidth'(phase_code));
          check_field("word_valid", WordWidth'(want.word_valid), WordWidth'(word_valid));
          check_field("word_index", WordWidth'(want.word_index), WordWidth'(word_index));
          check_field("word_data", want.word_data, word_data);
          check_field("frame_words", want.frame_words, frame_words);
        end
      end
      if (in_taken) expected_results.push_back(deframe_step(in_word));
      if (in_taken || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchLimit) begin
        $display("%0t: no request moved for %0d cycles", $time, WatchLimit);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    int unsigned          base_len;
    logic [WordWidth-1:0] sync_val;
    logic [WordWidth-1:0] cap_data;
    logic [CapWidth-1:0]  cap_val;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part at reset settings
    pending_words.push_back(32'h0000_0000);
    pending_words.push_back(32'hFFFF_FFFF);
    // zero length still takes one payload word
    pending_words.push_back(SYNC_RESET);
    pending_words.push_back(32'h0000_0000);
    pending_words.push_back(32'hFFFF_FFFF);
    pending_words.push_back(32'hFFFF_FFFF);
    // complete followed by a stray word drops to idle
    pending_words.push_back(32'h1234_5678);
    // sum wraps modulo 2^32
    pending_words.push_back(SYNC_RESET);
    pending_words.push_back(32'd2);
    pending_words.push_back(32'h8000_0000);
    pending_words.push_back(32'h8000_0001);
    pending_words.push_back(32'h0000_0001);
    // sync right after complete; bad checksum that equals the sync word
    pending_words.push_back(SYNC_RESET);
    pending_words.push_back(32'd1);
    pending_words.push_back(32'd5);
    pending_words.push_back(SYNC_RESET);
    pending_words.push_back(32'hFFFF_FFFF);
    pending_words.push_back(SYNC_RESET);
    pending_words.push_back(32'd3);
    pending_words.push_back(32'hAAAA_AAAA);
    pending_words.push_back(32'h5555_5555);
    pending_words.push_back(32'h0000_0000);
    pending_words.push_back(32'hFFFF_FFFF);
    wait_drained();

    // Random phases, one register setting each
    for (int k = 0; k < 6; k++) begin
      case (k)
        0: begin sync_val = 32'hFFFF_FFFF; cap_val = '0; end
        1: begin sync_val = 32'h0000_0000; cap_val = 17'd1; end
        2: begin sync_val = $urandom; cap_val = 17'd3; end
        3: begin sync_val = $urandom; cap_val = 17'd65536; end
        4: begin sync_val = $urandom; cap_val = 17'h1FFFF; end
        default: begin sync_val = $urandom; cap_val = CapWidth'($urandom_range(0, 16)); end
      endcase
      cap_data = $urandom;
      cap_data[CapWidth-1:0] = cap_val;
      write_reg(CFG_SYNC_WORD, sync_val);
      write_reg(CFG_CAPACITY, cap_data);
      if (k == 0) begin
        write_reg(CFG_SPARE_A, $urandom);
        write_reg(CFG_SPARE_B, $urandom);
      end
      steady_flow = (k == 2);
      base_len = pending_words.size();
      while (pending_words.size() - base_len < PhaseWords) push_random_traffic();
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (expected_results.size() != 0) begin
      mismatches++;
      $display("%0t: %0d results never arrived: expected 0 left, got %0d",
               $time, expected_results.size(), expected_results.size());
    end
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
